FILE: design/um32_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// um32_pkg: shared types and constants of the um32 execute unit
// Opcodes, memory request kinds, the decoded operation that travels from the
// front end to the back end, and the result beat.
// ----------------------------------------------------------------------------
package um32_pkg;

   localparam int UM32_WORD_W        = 32;
   localparam int UM32_REG_W         = 3;
   localparam int UM32_NUM_REGS      = 8;
   localparam int UM32_CHAR_W        = 8;
   localparam int UM32_OP_W          = 4;
   localparam int UM32_OP_SHIFT      = 28;
   localparam int UM32_IMM_REG_SHIFT = 25;
   localparam int UM32_IMM_W         = 25;
   localparam int UM32_KIND_W        = 3;

   // field positions of the three-register format
   localparam int UM32_RA_LSB = 6;
   localparam int UM32_RB_LSB = 3;
   localparam int UM32_RC_LSB = 0;

   // decoupling queue between front and back; depth is a power of two
   localparam int UM32_Q_DEPTH = 2;
   localparam int UM32_Q_PTR_W = $clog2(UM32_Q_DEPTH);
   localparam int UM32_Q_CNT_W = $clog2(UM32_Q_DEPTH + 1);

   localparam int UM32_DIV_CNT_W = $clog2(UM32_WORD_W);

   typedef enum logic [UM32_OP_W-1:0] {
      OP_CMOV  = 4'd0,
      OP_READ  = 4'd1,
      OP_WRITE = 4'd2,
      OP_ADD   = 4'd3,
      OP_MUL   = 4'd4,
      OP_DIV   = 4'd5,
      OP_NAND  = 4'd6,
      OP_HALT  = 4'd7,
      OP_ALLOC = 4'd8,
      OP_FREE  = 4'd9,
      OP_OUT   = 4'd10,
      OP_IN    = 4'd11,
      OP_LOADP = 4'd12,
      OP_LOADI = 4'd13
   } um32_op_type;

   typedef enum logic [UM32_KIND_W-1:0] {
      MEM_NONE  = 3'd0,
      MEM_READ  = 3'd1,
      MEM_WRITE = 3'd2,
      MEM_ALLOC = 3'd3,
      MEM_FREE  = 3'd4,
      MEM_LOAD  = 3'd5
   } um32_mem_kind_type;

   // decoded operation; imm carries the value for write-back, input and
   // load immediate, all of which write register ra
   typedef struct packed {
      logic                   writeback;
      logic [UM32_OP_W-1:0]   op;
      logic [UM32_REG_W-1:0]  ra;
      logic [UM32_REG_W-1:0]  rb;
      logic [UM32_REG_W-1:0]  rc;
      logic [UM32_WORD_W-1:0] imm;
   } um32_uop_type;

   typedef struct packed {
      logic empty;
      logic full;
   } um32_q_stat_type;

   typedef struct packed {
      logic [UM32_WORD_W-1:0] next_pc;
      logic                   halted;
      logic                   out_valid;
      logic [UM32_CHAR_W-1:0] out_char;
      um32_mem_kind_type      mem_kind;
      logic [UM32_WORD_W-1:0] mem_array;
      logic [UM32_WORD_W-1:0] mem_offset;
      logic [UM32_WORD_W-1:0] mem_data;
      logic [UM32_REG_W-1:0]  mem_dest;
      logic                   div_error;
   } um32_rsp_type;

endpackage
`default_nettype wire

FILE: design/um32_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// um32 channel interfaces
// Valid/ready channels for instruction beats and result beats.
// ----------------------------------------------------------------------------
interface um32_req_if import um32_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic                   cmd;
   logic [UM32_WORD_W-1:0] instr_word;
   logic [UM32_CHAR_W-1:0] in_char;
   logic                   in_eof;
   logic [UM32_REG_W-1:0]  return_reg;
   logic [UM32_WORD_W-1:0] return_value;

   modport source (output valid, cmd, instr_word, in_char, in_eof, return_reg,
                   return_value, input ready);
   modport sink   (input valid, cmd, instr_word, in_char, in_eof, return_reg,
                   return_value, output ready);
endinterface

interface um32_rsp_if import um32_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [UM32_WORD_W-1:0] next_pc;
   logic                   halted;
   logic                   out_valid;
   logic [UM32_CHAR_W-1:0] out_char;
   logic [UM32_KIND_W-1:0] mem_kind;
   logic [UM32_WORD_W-1:0] mem_array;
   logic [UM32_WORD_W-1:0] mem_offset;
   logic [UM32_WORD_W-1:0] mem_data;
   logic [UM32_REG_W-1:0]  mem_dest;
   logic                   div_error;

   modport source (output valid, next_pc, halted, out_valid, out_char, mem_kind,
                   mem_array, mem_offset, mem_data, mem_dest, div_error,
                   input ready);
   modport sink   (input valid, next_pc, halted, out_valid, out_char, mem_kind,
                   mem_array, mem_offset, mem_data, mem_dest, div_error,
                   output ready);
endinterface
`default_nettype wire

FILE: design/um32_execute_unit.sv
`default_nettype none
// Timing: array write takes an extra operand read step, and a divide with
//   nonzero divisor runs in the bit-serial divider.
// Flow: the back end runs one item at a time; the 2-entry queue keeps taking
//   beats while it has room.
// Reset: synchronous; clears registers, pc, halt flag, queue and result slot.
// ----------------------------------------------------------------------------
// um32_execute_unit: instruction execute unit
// Front end decodes request beats into a short queue; the back end executes
// them against the register file and emits one result beat per item.
// ----------------------------------------------------------------------------
module um32_execute_unit import um32_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   um32_req_if.sink     req_bus,
   um32_rsp_if.source   rsp_bus
);

   um32_q_stat_type q_stat;
   um32_uop_type    push_uop;
   um32_uop_type    head_uop;
   logic            q_push;
   logic            q_pop;

   um32_front u_front (
      .req_bus  (req_bus),
      .q_stat   (q_stat),
      .push     (q_push),
      .push_uop (push_uop)
   );

   um32_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_uop (push_uop),
      .pop      (q_pop),
      .head_uop (head_uop),
      .q_stat   (q_stat)
   );

   um32_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .head_uop (head_uop),
      .pop      (q_pop),
      .rsp_bus  (rsp_bus)
   );

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("back end popped an empty queue");

   a_halt_beat_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.halted |->
         rsp_bus.mem_kind == MEM_NONE && !rsp_bus.out_valid && !rsp_bus.div_error)
      else $error("halted result carries a request");

   a_mem_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.mem_kind != MEM_NONE |->
         !rsp_bus.out_valid && !rsp_bus.div_error)
      else $error("memory request mixed with output or divide error");

   a_pop_needs_slot: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !rsp_bus.valid)
      else $error("operation started while result slot still held");

endmodule
`default_nettype wire

FILE: design/um32_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// um32_front: accept and decode
// Takes request beats while the queue has room and splits the instruction
// word into a decoded operation for the back end.
// ----------------------------------------------------------------------------
module um32_front import um32_pkg::*; (
   um32_req_if.sink        req_bus,
   input  um32_q_stat_type q_stat,
   output logic            push,
   output um32_uop_type    push_uop
);

   logic [UM32_OP_W-1:0]  op;
   logic [UM32_REG_W-1:0] fld_a;
   logic [UM32_REG_W-1:0] fld_b;
   logic [UM32_REG_W-1:0] fld_c;
   logic [UM32_REG_W-1:0] fld_imm_reg;

   assign req_bus.ready = !q_stat.full;
   assign push          = req_bus.valid && !q_stat.full;

   assign op          = req_bus.instr_word[UM32_OP_SHIFT +: UM32_OP_W];
   assign fld_a       = req_bus.instr_word[UM32_RA_LSB +: UM32_REG_W];
   assign fld_b       = req_bus.instr_word[UM32_RB_LSB +: UM32_REG_W];
   assign fld_c       = req_bus.instr_word[UM32_RC_LSB +: UM32_REG_W];
   assign fld_imm_reg = req_bus.instr_word[UM32_IMM_REG_SHIFT +: UM32_REG_W];

   always_comb begin
      push_uop.writeback = req_bus.cmd;
      push_uop.op        = op;
      push_uop.rb        = fld_b;
      push_uop.rc        = fld_c;
      if (req_bus.cmd) begin
         push_uop.ra  = req_bus.return_reg;
         push_uop.imm = req_bus.return_value;
      end else if (op == OP_LOADI) begin
         push_uop.ra  = fld_imm_reg;
         push_uop.imm = UM32_WORD_W'(req_bus.instr_word[UM32_IMM_W-1:0]);
      end else if (op == OP_IN) begin
         push_uop.ra  = fld_c;
         push_uop.imm = req_bus.in_eof ? '1 : UM32_WORD_W'(req_bus.in_char);
      end else begin
         push_uop.ra  = fld_a;
         push_uop.imm = '0;
      end
   end

endmodule
`default_nettype wire

FILE: design/um32_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// um32_queue: decoupling queue
// Short FIFO of decoded operations between the front and back ends.
// ----------------------------------------------------------------------------
module um32_queue import um32_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  um32_uop_type    push_uop,
   input  logic            pop,
   output um32_uop_type    head_uop,
   output um32_q_stat_type q_stat
);

   um32_uop_type            slot_ff [UM32_Q_DEPTH];
   logic [UM32_Q_PTR_W-1:0] wr_ptr_ff;
   logic [UM32_Q_PTR_W-1:0] wr_ptr_in;
   logic [UM32_Q_PTR_W-1:0] rd_ptr_ff;
   logic [UM32_Q_PTR_W-1:0] rd_ptr_in;
   logic [UM32_Q_CNT_W-1:0] cnt_ff;
   logic [UM32_Q_CNT_W-1:0] cnt_in;

   assign head_uop     = slot_ff[rd_ptr_ff];
   assign q_stat.empty = (cnt_ff == '0);
   assign q_stat.full  = (cnt_ff == UM32_Q_CNT_W'(UM32_Q_DEPTH));

   always_comb begin
      wr_ptr_in = push ? UM32_Q_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? UM32_Q_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   cnt_in = UM32_Q_CNT_W'(cnt_ff + 1'b1);
         2'b01:   cnt_in = UM32_Q_CNT_W'(cnt_ff - 1'b1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_uop;
      end
   end

endmodule
`default_nettype wire

FILE: design/um32_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// um32_divider: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses when the last
// bit is registered, together with the full quotient. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module um32_divider import um32_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [UM32_WORD_W-1:0] dividend,
   input  logic [UM32_WORD_W-1:0] divisor,
   output logic                   done,
   output logic [UM32_WORD_W-1:0] quotient
);

   logic                      busy_ff;
   logic                      busy_in;
   logic                      done_ff;
   logic                      done_in;
   logic [UM32_DIV_CNT_W-1:0] cnt_ff;
   logic [UM32_DIV_CNT_W-1:0] cnt_in;
   logic [UM32_WORD_W-1:0]    rem_ff;
   logic [UM32_WORD_W-1:0]    rem_in;
   logic [UM32_WORD_W-1:0]    quo_ff;
   logic [UM32_WORD_W-1:0]    quo_in;
   logic [UM32_WORD_W-1:0]    dsr_ff;
   logic [UM32_WORD_W-1:0]    dsr_in;
   logic [UM32_WORD_W:0]      rem_shift;
   logic [UM32_WORD_W:0]      diff;

   assign done     = done_ff;
   assign quotient = quo_ff;

   assign rem_shift = {rem_ff, quo_ff[UM32_WORD_W-1]};
   assign diff      = rem_shift - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // keep the difference when it did not borrow
         if (!diff[UM32_WORD_W]) begin
            rem_in = diff[UM32_WORD_W-1:0];
            quo_in = {quo_ff[UM32_WORD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[UM32_WORD_W-1:0];
            quo_in = {quo_ff[UM32_WORD_W-2:0], 1'b0};
         end
         cnt_in = UM32_DIV_CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

endmodule
`default_nettype wire

FILE: design/um32_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// um32_back: execute back end
// Owns the register file, program counter and halt flag; pops one decoded
// operation at a time, reads operands, executes and loads the result beat.
// ----------------------------------------------------------------------------
module um32_back import um32_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  um32_q_stat_type q_stat,
   input  um32_uop_type    head_uop,
   output logic            pop,
   um32_rsp_if.source      rsp_bus
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_OPER_A,
      S_EXEC,
      S_DIV
   } state_type;

   state_type              state_ff;
   state_type              state_in;
   logic [UM32_WORD_W-1:0] pc_ff;
   logic [UM32_WORD_W-1:0] pc_in;
   logic                   halt_ff;
   logic                   halt_in;
   um32_uop_type           uop_ff;
   um32_uop_type           uop_in;
   logic [UM32_WORD_W-1:0] bsave_ff;
   logic [UM32_WORD_W-1:0] bsave_in;
   um32_rsp_type           rsp_ff;
   um32_rsp_type           rsp_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   // register file: two registered read ports, one write port
   logic [UM32_WORD_W-1:0] regfile_mem [UM32_NUM_REGS];
   logic [UM32_NUM_REGS-1:0] rf_valid_ff;
   logic [UM32_REG_W-1:0]  rd0_addr;
   logic [UM32_REG_W-1:0]  rd1_addr;
   logic [UM32_WORD_W-1:0] rd0_ff;
   logic [UM32_WORD_W-1:0] rd1_ff;
   logic                   rf_we;
   logic [UM32_REG_W-1:0]  rf_waddr;
   logic [UM32_WORD_W-1:0] rf_wdata;

   logic                   div_start;
   logic                   div_done;
   logic [UM32_WORD_W-1:0] div_quo;
   logic [UM32_WORD_W-1:0] npc;
   logic                   load_rsp;
   um32_rsp_type           res;

   um32_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd0_ff),
      .divisor  (rd1_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      halt_in      = halt_ff;
      uop_in       = uop_ff;
      bsave_in     = bsave_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      pop          = 1'b0;
      rd0_addr     = uop_ff.rb;
      rd1_addr     = uop_ff.rc;
      rf_we        = 1'b0;
      rf_waddr     = uop_ff.ra;
      rf_wdata     = uop_ff.imm;
      div_start    = 1'b0;
      npc          = UM32_WORD_W'(pc_ff + 1'b1);
      load_rsp     = 1'b0;
      res          = '0;

      case (state_ff)
         S_IDLE: begin
            rd0_addr = head_uop.rb;
            rd1_addr = head_uop.rc;
            // take the next operation only once the result slot is free
            if (!q_stat.empty && (!rsp_valid_ff || rsp_bus.ready)) begin
               pop    = 1'b1;
               uop_in = head_uop;
               if (!head_uop.writeback && head_uop.op == OP_WRITE) begin
                  state_in = S_OPER_A;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_OPER_A: begin
            // array write needs A as well: save B, read A on port 0
            rd0_addr = uop_ff.ra;
            bsave_in = rd0_ff;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
            load_rsp = 1'b1;
            if (uop_ff.writeback) begin
               rf_we = 1'b1;
               npc   = pc_ff;
            end else if (halt_ff) begin
               npc = pc_ff;
            end else begin
               case (uop_ff.op)
                  OP_CMOV: begin
                     rf_we    = (rd1_ff != '0);
                     rf_wdata = rd0_ff;
                  end
                  OP_READ: begin
                     res.mem_kind   = MEM_READ;
                     res.mem_array  = rd0_ff;
                     res.mem_offset = rd1_ff;
                     res.mem_dest   = uop_ff.ra;
                  end
                  OP_WRITE: begin
                     res.mem_kind   = MEM_WRITE;
                     res.mem_array  = rd0_ff;
                     res.mem_offset = bsave_ff;
                     res.mem_data   = rd1_ff;
                  end
                  OP_ADD: begin
                     rf_we    = 1'b1;
                     rf_wdata = rd0_ff + rd1_ff;
                  end
                  OP_MUL: begin
                     rf_we    = 1'b1;
                     rf_wdata = UM32_WORD_W'(rd0_ff * rd1_ff);
                  end
                  OP_DIV: begin
                     if (rd1_ff == '0) begin
                        res.div_error = 1'b1;
                     end else begin
                        div_start = 1'b1;
                        load_rsp  = 1'b0;
                        state_in  = S_DIV;
                     end
                  end
                  OP_NAND: begin
                     rf_we    = 1'b1;
                     rf_wdata = ~(rd0_ff & rd1_ff);
                  end
                  OP_HALT: begin
                     halt_in = 1'b1;
                     npc     = pc_ff;
                  end
                  OP_ALLOC: begin
                     res.mem_kind   = MEM_ALLOC;
                     res.mem_offset = rd1_ff;
                     res.mem_dest   = uop_ff.rb;
                  end
                  OP_FREE: begin
                     res.mem_kind  = MEM_FREE;
                     res.mem_array = rd1_ff;
                  end
                  OP_OUT: begin
                     res.out_valid = 1'b1;
                     res.out_char  = rd1_ff[UM32_CHAR_W-1:0];
                  end
                  OP_IN, OP_LOADI: begin
                     rf_we = 1'b1;
                  end
                  OP_LOADP: begin
                     res.mem_kind   = MEM_LOAD;
                     res.mem_array  = rd0_ff;
                     res.mem_offset = rd1_ff;
                     npc            = rd1_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               rf_we    = 1'b1;
               rf_wdata = div_quo;
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load_rsp) begin
         res.next_pc  = npc;
         res.halted   = halt_in;
         pc_in        = npc;
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      uop_ff   <= uop_in;
      bsave_ff <= bsave_in;
      rsp_ff   <= rsp_in;
   end

   // entries not yet written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
      end else if (rf_we) begin
         rf_valid_ff[rf_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         regfile_mem[rf_waddr] <= rf_wdata;
      end
      rd0_ff <= rf_valid_ff[rd0_addr] ? regfile_mem[rd0_addr] : '0;
      rd1_ff <= rf_valid_ff[rd1_addr] ? regfile_mem[rd1_addr] : '0;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.next_pc    = rsp_ff.next_pc;
   assign rsp_bus.halted     = rsp_ff.halted;
   assign rsp_bus.out_valid  = rsp_ff.out_valid;
   assign rsp_bus.out_char   = rsp_ff.out_char;
   assign rsp_bus.mem_kind   = rsp_ff.mem_kind;
   assign rsp_bus.mem_array  = rsp_ff.mem_array;
   assign rsp_bus.mem_offset = rsp_ff.mem_offset;
   assign rsp_bus.mem_data   = rsp_ff.mem_data;
   assign rsp_bus.mem_dest   = rsp_ff.mem_dest;
   assign rsp_bus.div_error  = rsp_ff.div_error;

endmodule
`default_nettype wire
